/* rtl/heightmap_bilinear_sampler_unit_macros.svh */
// Assertion macros for heightmap_bilinear_sampler_unit.sv.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define HBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hbs_pkg.sv */
package hbs_pkg;

    localparam int HBS_GRID_SIZE = 64;

    localparam int ACTION_W = 2;
    localparam int COORD_W  = 6;
    localparam int HEIGHT_W = 16;
    localparam int DELTA_W  = 17;
    localparam int POS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RADIUS_W = 15;
    localparam int SCALE_W  = 16;
    localparam int BRUSH_W  = 6;
    localparam int WT_W     = 9;

    localparam logic [RADIUS_W-1:0] WORLD_RADIUS_RST = 15'd1280;
    localparam logic [SCALE_W-1:0]  GRID_SCALE_RST   = 16'd1600;
    localparam logic [BRUSH_W-1:0]  BRUSH_RADIUS_RST = 6'd0;
    localparam logic [WT_W-1:0]     WT_ONE           = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_RADIUS = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BRUSH  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_MAP,
        S_CLAMP,
        S_SREAD,
        S_SWAIT,
        S_MIX0,
        S_MIX1,
        S_MIX2,
        S_BRUSH,
        S_BDRAIN,
        S_DONE
    } t_state;

endpackage

/* rtl/hbs_if.sv */
interface hbs_in_if;
    import hbs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic [HEIGHT_W-1:0]        height_value;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [POS_W-1:0]    x_pos;
    logic signed [POS_W-1:0]    z_pos;
    modport source (output valid, action, row, col, height_value, delta, x_pos, z_pos,
                    input ready);
    modport sink (input valid, action, row, col, height_value, delta, x_pos, z_pos,
                  output ready);
endinterface

interface hbs_out_if;
    import hbs_pkg::*;
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] elevation;
    logic                clipped;
    modport source (output valid, elevation, clipped, input ready);
    modport sink (input valid, elevation, clipped, output ready);
endinterface

interface hbs_cfg_if;
    import hbs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/hbs_ram.sv */
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/heightmap_bilinear_sampler_unit.sv */
// A write passes through S_DISP and S_DONE; a sample through S_DISP, S_MAP, S_CLAMP,
// S_SREAD, S_SWAIT, S_MIX0 to S_MIX2 and S_DONE; a brush through S_DISP, S_BRUSH for
// each covered grid cell, S_BDRAIN and S_DONE. One request is in work at a time; the next
// is accepted once S_DONE has moved the result into a free output register.
// A sample reads its four cells one by one in S_SREAD through the single read port of the memory.
// Synchronous active-low reset clears control and sets configuration to its defaults; heights stay.
`include "heightmap_bilinear_sampler_unit_macros.svh"

module heightmap_bilinear_sampler_unit #(
    parameter int GRID_SIZE = hbs_pkg::HBS_GRID_SIZE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hbs_in_if.sink    i_in,
    hbs_cfg_if.sink   i_cfg,
    hbs_out_if.source o_out
);
    import hbs_pkg::*;

    localparam int IDX_W  = $clog2(GRID_SIZE);
    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int P_W    = 35;
    localparam int ROW_W  = 25;
    localparam int MIX_W  = 34;
    localparam int RNG_W  = 10;
    localparam logic signed [P_W-1:0]   P_TOP    = P_W'((GRID_SIZE - 1) * 65536);
    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(GRID_SIZE - 1);
    localparam logic signed [RNG_W-1:0] RNG_LAST = RNG_W'(GRID_SIZE - 1);

    t_state r_state, n_state;

    logic [RADIUS_W-1:0] r_world_radius;
    logic [SCALE_W-1:0]  r_grid_scale;
    logic [BRUSH_W-1:0]  r_brush_radius;

    logic [ACTION_W-1:0]       r_action, n_action;
    logic [COORD_W-1:0]        r_row, n_row;
    logic [COORD_W-1:0]        r_col, n_col;
    logic [HEIGHT_W-1:0]       r_height, n_height;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic signed [POS_W-1:0]   r_x, n_x;
    logic signed [POS_W-1:0]   r_z, n_z;

    logic signed [P_W-1:0] r_ppx, n_ppx;
    logic signed [P_W-1:0] r_ppz, n_ppz;
    logic [IDX_W-1:0]      r_px, n_px;
    logic [IDX_W-1:0]      r_pz, n_pz;
    logic [WT_W-1:0]       r_fx, n_fx;
    logic [WT_W-1:0]       r_fz, n_fz;
    logic                  r_clip, n_clip;

    logic [1:0]       r_cnt, n_cnt;
    logic             r_rv, n_rv;
    logic [1:0]       r_rtag, n_rtag;
    logic             r_pv, n_pv;
    logic [1:0]       r_ptag, n_ptag;
    logic [ROW_W-1:0] r_prod, n_prod;
    logic [ROW_W-1:0] r_part, n_part;
    logic [ROW_W-1:0] r_up, n_up;
    logic [ROW_W-1:0] r_lo, n_lo;
    logic [MIX_W-1:0] r_mprod, n_mprod;
    logic [MIX_W-1:0] r_macc, n_macc;

    logic [IDX_W-1:0]  r_bi, n_bi;
    logic [IDX_W-1:0]  r_bj, n_bj;
    logic [IDX_W-1:0]  r_rhi, n_rhi;
    logic [IDX_W-1:0]  r_clo, n_clo;
    logic [IDX_W-1:0]  r_chi, n_chi;
    logic              r_bv, n_bv;
    logic [ADDR_W-1:0] r_baddr, n_baddr;

    logic [HEIGHT_W-1:0] r_elev, n_elev;
    logic                r_res_clip, n_res_clip;
    logic                r_out_valid, n_out_valid;
    logic [HEIGHT_W-1:0] r_out_elev, n_out_elev;
    logic                r_out_clip, n_out_clip;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [HEIGHT_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [HEIGHT_W-1:0] mem_rdata;

    logic signed [17:0]       ux, uz;
    logic signed [16:0]       scale_s;
    logic [IDX_W+WT_W:0]      map_x, map_z;
    logic [WT_W-1:0]          wsel;
    logic signed [RNG_W-1:0]  rlo_s, rhi_s, clo_s, chi_s, ctr_r, ctr_c, br_s;
    logic signed [18:0]       bsum;
    logic [HEIGHT_W-1:0]      bnew;
    logic [MIX_W-1:0]         mix_sum;
    logic                     in_grid;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c);
    endfunction

    function automatic logic [IDX_W+WT_W:0] map_coord(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] pc;
        logic                  clip;
        logic [IDX_W-1:0]      idx;
        logic [WT_W-1:0]       wt;
        pc   = p;
        clip = 1'b0;
        if (p < 0) begin
            pc   = '0;
            clip = 1'b1;
        end else if (p > P_TOP) begin
            pc   = P_TOP;
            clip = 1'b1;
        end
        idx = pc[16 +: IDX_W];
        wt  = {1'b0, pc[15:8]};
        if (idx >= LAST_IDX) begin
            idx = LAST_IDX - IDX_W'(1);
            wt  = WT_ONE;
        end
        return {clip, wt, idx};
    endfunction

    hbs_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.elevation = r_out_elev;
    assign o_out.clipped   = r_out_clip;

    always_comb begin
        ux      = $signed({{2{r_x[POS_W-1]}}, r_x}) + $signed({3'b000, r_world_radius});
        uz      = $signed({{2{r_z[POS_W-1]}}, r_z}) + $signed({3'b000, r_world_radius});
        scale_s = $signed({1'b0, r_grid_scale});
        map_x   = map_coord(r_ppx);
        map_z   = map_coord(r_ppz);
        wsel    = r_rtag[0] ? r_fx : (WT_ONE - r_fx);
        ctr_r   = $signed(RNG_W'(r_row));
        ctr_c   = $signed(RNG_W'(r_col));
        br_s    = $signed(RNG_W'(r_brush_radius));
        rlo_s   = ctr_r - br_s;
        rhi_s   = ctr_r + br_s;
        clo_s   = ctr_c - br_s;
        chi_s   = ctr_c + br_s;
        if (rlo_s < 0) begin
            rlo_s = '0;
        end
        if (clo_s < 0) begin
            clo_s = '0;
        end
        if (rhi_s > RNG_LAST) begin
            rhi_s = RNG_LAST;
        end
        if (chi_s > RNG_LAST) begin
            chi_s = RNG_LAST;
        end
        bsum = $signed({3'b000, mem_rdata}) + $signed({{2{r_delta[DELTA_W-1]}}, r_delta});
        if (bsum < 0) begin
            bnew = '0;
        end else if (bsum > 19'sd65535) begin
            bnew = '1;
        end else begin
            bnew = bsum[HEIGHT_W-1:0];
        end
        mix_sum = r_macc + r_mprod + MIX_W'(32768);
        in_grid = (RNG_W'(r_row) < RNG_W'(GRID_SIZE)) && (RNG_W'(r_col) < RNG_W'(GRID_SIZE));
    end

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_row       = r_row;
        n_col       = r_col;
        n_height    = r_height;
        n_delta     = r_delta;
        n_x         = r_x;
        n_z         = r_z;
        n_ppx       = r_ppx;
        n_ppz       = r_ppz;
        n_px        = r_px;
        n_pz        = r_pz;
        n_fx        = r_fx;
        n_fz        = r_fz;
        n_clip      = r_clip;
        n_cnt       = r_cnt;
        n_rv        = 1'b0;
        n_rtag      = r_cnt;
        n_pv        = r_rv;
        n_ptag      = r_rtag;
        n_prod      = ROW_W'(mem_rdata) * ROW_W'(wsel);
        n_part      = r_part;
        n_up        = r_up;
        n_lo        = r_lo;
        n_mprod     = r_mprod;
        n_macc      = r_macc;
        n_bi        = r_bi;
        n_bj        = r_bj;
        n_rhi       = r_rhi;
        n_clo       = r_clo;
        n_chi       = r_chi;
        n_bv        = 1'b0;
        n_baddr     = cell_addr(r_bi, r_bj);
        n_elev      = r_elev;
        n_res_clip  = r_res_clip;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_elev  = r_out_elev;
        n_out_clip  = r_out_clip;
        mem_we      = 1'b0;
        mem_waddr   = r_baddr;
        mem_wdata   = bnew;
        mem_raddr   = cell_addr(r_bi, r_bj);

        if (r_pv) begin
            if (!r_ptag[0]) begin
                n_part = r_prod;
            end else if (r_ptag[1]) begin
                n_lo = r_part + r_prod;
            end else begin
                n_up = r_part + r_prod;
            end
        end

        if (r_bv) begin
            mem_we = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action = i_in.action;
                    n_row    = i_in.row;
                    n_col    = i_in.col;
                    n_height = i_in.height_value;
                    n_delta  = i_in.delta;
                    n_x      = i_in.x_pos;
                    n_z      = i_in.z_pos;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_elev     = '0;
                n_res_clip = 1'b0;
                n_state    = S_DONE;
                unique case (r_action)
                    ACT_WRITE: begin
                        if (in_grid) begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(IDX_W'(r_row), IDX_W'(r_col));
                            mem_wdata = r_height;
                        end
                    end
                    ACT_SAMPLE: begin
                        n_state = S_MAP;
                    end
                    ACT_BRUSH: begin
                        n_rhi = IDX_W'(rhi_s);
                        n_clo = IDX_W'(clo_s);
                        n_chi = IDX_W'(chi_s);
                        n_bi  = IDX_W'(rlo_s);
                        n_bj  = IDX_W'(clo_s);
                        if ((rlo_s <= rhi_s) && (clo_s <= chi_s)) begin
                            n_state = S_BRUSH;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MAP: begin
                n_ppx   = ux * scale_s;
                n_ppz   = uz * scale_s;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_px    = map_x[IDX_W-1:0];
                n_fx    = map_x[IDX_W +: WT_W];
                n_pz    = map_z[IDX_W-1:0];
                n_fz    = map_z[IDX_W +: WT_W];
                n_clip  = map_x[IDX_W+WT_W] | map_z[IDX_W+WT_W];
                n_cnt   = 2'd0;
                n_state = S_SREAD;
            end
            S_SREAD: begin
                mem_raddr = cell_addr(r_pz + IDX_W'(r_cnt[1]), r_px + IDX_W'(r_cnt[0]));
                n_rv      = 1'b1;
                n_cnt     = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (r_pv && (r_ptag == 2'd3)) begin
                    n_state = S_MIX0;
                end
            end
            S_MIX0: begin
                n_mprod = MIX_W'(r_up) * MIX_W'(WT_ONE - r_fz);
                n_state = S_MIX1;
            end
            S_MIX1: begin
                n_macc  = r_mprod;
                n_mprod = MIX_W'(r_lo) * MIX_W'(r_fz);
                n_state = S_MIX2;
            end
            S_MIX2: begin
                n_elev     = mix_sum[31:16];
                n_res_clip = r_clip;
                n_state    = S_DONE;
            end
            S_BRUSH: begin
                n_bv = 1'b1;
                if (r_bj == r_chi) begin
                    n_bj = r_clo;
                    if (r_bi == r_rhi) begin
                        n_state = S_BDRAIN;
                    end else begin
                        n_bi = r_bi + IDX_W'(1);
                    end
                end else begin
                    n_bj = r_bj + IDX_W'(1);
                end
            end
            S_BDRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_elev  = r_elev;
                    n_out_clip  = r_res_clip;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_rv           <= 1'b0;
            r_pv           <= 1'b0;
            r_bv           <= 1'b0;
            r_world_radius <= WORLD_RADIUS_RST;
            r_grid_scale   <= GRID_SCALE_RST;
            r_brush_radius <= BRUSH_RADIUS_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rv        <= n_rv;
            r_pv        <= n_pv;
            r_bv        <= n_bv;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_WORLD_RADIUS: r_world_radius <= i_cfg.data[RADIUS_W-1:0];
                    CFG_GRID_SCALE:   r_grid_scale   <= i_cfg.data[SCALE_W-1:0];
                    CFG_BRUSH_RADIUS: r_brush_radius <= i_cfg.data[BRUSH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_row      <= n_row;
        r_col      <= n_col;
        r_height   <= n_height;
        r_delta    <= n_delta;
        r_x        <= n_x;
        r_z        <= n_z;
        r_ppx      <= n_ppx;
        r_ppz      <= n_ppz;
        r_px       <= n_px;
        r_pz       <= n_pz;
        r_fx       <= n_fx;
        r_fz       <= n_fz;
        r_clip     <= n_clip;
        r_cnt      <= n_cnt;
        r_rtag     <= n_rtag;
        r_ptag     <= n_ptag;
        r_prod     <= n_prod;
        r_part     <= n_part;
        r_up       <= n_up;
        r_lo       <= n_lo;
        r_mprod    <= n_mprod;
        r_macc     <= n_macc;
        r_bi       <= n_bi;
        r_bj       <= n_bj;
        r_rhi      <= n_rhi;
        r_clo      <= n_clo;
        r_chi      <= n_chi;
        r_baddr    <= n_baddr;
        r_elev     <= n_elev;
        r_res_clip <= n_res_clip;
        r_out_elev <= n_out_elev;
        r_out_clip <= n_out_clip;
    end

    `HBS_ASSERT_NOW(a_no_write_in_sample, (r_state == S_SREAD) || (r_state == S_SWAIT), !mem_we, "height store written during a sample")
    `HBS_ASSERT_NOW(a_sample_in_grid, r_state == S_SREAD, (r_px < LAST_IDX) && (r_pz < LAST_IDX), "sample cell index beyond the grid")
    `HBS_ASSERT_NOW(a_brush_in_grid, r_state == S_BRUSH, (r_bi <= r_rhi) && (r_bj <= r_chi) && (r_rhi <= LAST_IDX) && (r_chi <= LAST_IDX), "brush cell outside its range")
    `HBS_ASSERT_NEXT(a_done_holds, (r_state == S_DONE) && r_out_valid && !o_out.ready, r_state == S_DONE, "finished result dropped while output is stalled")

endmodule
